>>> hw/rtl/assert_macros.svh
// Assertion shorthands for the pair kinematics block.
// Expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PRK_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pair kinematics assertion failed");

// next-cycle implication
`define PRK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pair kinematics assertion failed");

`endif

>>> hw/rtl/prk_pkg.sv
// Shared types and widths for the pair rest-frame kinematics pipeline.
// No dependencies.
`default_nettype none

package prk_pkg;

    localparam int WORD_BITS = 32;
    localparam int SUM_BITS  = WORD_BITS + 1;
    localparam int PROD_BITS = 2 * SUM_BITS;
    localparam int SQIN_BITS = PROD_BITS + 2;
    localparam int ROOT_BITS = SQIN_BITS / 2;
    localparam int NUM_BITS  = ROOT_BITS + WORD_BITS + 2;
    localparam int MAG_BITS  = 2 * WORD_BITS;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] mom_x_first;
        logic signed [WORD_BITS-1:0] mom_y_first;
        logic signed [WORD_BITS-1:0] mom_z_first;
        logic        [WORD_BITS-2:0] energy_first;
        logic signed [WORD_BITS-1:0] mom_x_second;
        logic signed [WORD_BITS-1:0] mom_y_second;
        logic signed [WORD_BITS-1:0] mom_z_second;
        logic        [WORD_BITS-2:0] energy_second;
        logic signed [WORD_BITS-1:0] sep_x;
        logic signed [WORD_BITS-1:0] sep_y;
        logic signed [WORD_BITS-1:0] sep_z;
        logic signed [WORD_BITS-1:0] sep_time;
    } prk_pair_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] k_out;
        logic signed [WORD_BITS-1:0] k_side;
        logic signed [WORD_BITS-1:0] k_long;
        logic signed [WORD_BITS-1:0] k_star;
        logic signed [WORD_BITS-1:0] r_out;
        logic signed [WORD_BITS-1:0] r_side;
        logic signed [WORD_BITS-1:0] r_long;
        logic        [WORD_BITS-2:0] r_star;
        logic                        invalid;
    } prk_kin_t;

    // first-level numerators riding along the pair-mass square roots
    typedef struct packed {
        logic [7:0][NUM_BITS-1:0] num;
        logic                     invalid;
    } prk_side_a_t;

    // roots riding along the first divider bank
    typedef struct packed {
        logic [ROOT_BITS-1:0] pt;
        logic [ROOT_BITS-1:0] mt;
        logic [ROOT_BITS-1:0] m;
        logic                 invalid;
    } prk_side_d_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] m;
        logic [WORD_BITS-1:0] kside;
        logic [WORD_BITS-1:0] klong;
        logic [WORD_BITS-1:0] rside;
        logic [WORD_BITS-1:0] rlong;
        logic                 invalid;
    } prk_side_b_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] kout;
        logic [WORD_BITS-1:0] kside;
        logic [WORD_BITS-1:0] klong;
        logic [WORD_BITS-1:0] rout;
        logic [WORD_BITS-1:0] rside;
        logic [WORD_BITS-1:0] rlong;
        logic                 invalid;
    } prk_side_c_t;

endpackage

`default_nettype wire

>>> hw/rtl/pair_rest_frame_kinematics.sv
// Pair rest-frame kinematics: LCMS boost, out/side/long rotation, boost to PRF.
// Depends on prk_pkg and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   pair    | in        | pair_valid/pair_stall | prk_pair_t
//   kin     | out       | kin_valid/kin_stall   | prk_kin_t
//
// One pair per cycle while the output is not stalled; the pipeline depth is set by
// the bit-per-stage square roots and the bit-per-stage dividers.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset clears only the stage valid bits.
`default_nettype none

module pair_rest_frame_kinematics
    import prk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pair_valid,
    output logic      pair_stall,
    input  prk_pair_t pair,
    output logic      kin_valid,
    input  logic      kin_stall,
    output prk_kin_t  kin
);

    localparam int LAT     = 3 * WORD_BITS + ROOT_BITS + 12;
    localparam int CA_BITS = SQIN_BITS + 2;
    localparam int CB_BITS = MAG_BITS + 2;
    localparam logic [7:0] USE_MT = 8'b0011_0011;
    localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic logic [WORD_BITS-1:0] quot_fix(input logic neg, input logic sat,
                                                      input logic [WORD_BITS-1:0] q);
        logic [WORD_BITS-1:0] lim;
        logic [WORD_BITS-1:0] mag;
        lim = neg ? LIM_NEG : LIM_POS;
        mag = (sat || (q > lim)) ? lim : q;
        return neg ? -mag : mag;
    endfunction

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en         = !vld_reg[LAT-1] || !kin_stall;
    assign pair_stall = !en;
    assign kin_valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pair_valid};
        end
    end

    // stage 1: pair sums, plus first-particle momentum, energy and separation
    logic signed [SUM_BITS-1:0] s1_sx_reg, s1_sy_reg, s1_sz_reg, s1_se_reg;
    logic signed [SUM_BITS-1:0] s1_px_reg, s1_py_reg, s1_pz_reg, s1_e_reg;
    logic signed [SUM_BITS-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg, s1_dt_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sx_reg <= SUM_BITS'(pair.mom_x_first) + SUM_BITS'(pair.mom_x_second);
            s1_sy_reg <= SUM_BITS'(pair.mom_y_first) + SUM_BITS'(pair.mom_y_second);
            s1_sz_reg <= SUM_BITS'(pair.mom_z_first) + SUM_BITS'(pair.mom_z_second);
            s1_se_reg <= SUM_BITS'(pair.energy_first) + SUM_BITS'(pair.energy_second);
            s1_px_reg <= SUM_BITS'(pair.mom_x_first);
            s1_py_reg <= SUM_BITS'(pair.mom_y_first);
            s1_pz_reg <= SUM_BITS'(pair.mom_z_first);
            s1_e_reg  <= SUM_BITS'(pair.energy_first);
            s1_dx_reg <= SUM_BITS'(pair.sep_x);
            s1_dy_reg <= SUM_BITS'(pair.sep_y);
            s1_dz_reg <= SUM_BITS'(pair.sep_z);
            s1_dt_reg <= SUM_BITS'(pair.sep_time);
        end
    end

    // stage 2: products
    logic signed [SUM_BITS-1:0]  mul_a [20];
    logic signed [SUM_BITS-1:0]  mul_b [20];
    logic signed [PROD_BITS-1:0] s2_p_reg [20];

    always_comb
    begin
        mul_a[0]  = s1_sx_reg; mul_b[0]  = s1_sx_reg;
        mul_a[1]  = s1_sy_reg; mul_b[1]  = s1_sy_reg;
        mul_a[2]  = s1_se_reg; mul_b[2]  = s1_se_reg;
        mul_a[3]  = s1_sz_reg; mul_b[3]  = s1_sz_reg;
        mul_a[4]  = s1_se_reg; mul_b[4]  = s1_pz_reg;
        mul_a[5]  = s1_sz_reg; mul_b[5]  = s1_e_reg;
        mul_a[6]  = s1_se_reg; mul_b[6]  = s1_e_reg;
        mul_a[7]  = s1_sz_reg; mul_b[7]  = s1_pz_reg;
        mul_a[8]  = s1_px_reg; mul_b[8]  = s1_sx_reg;
        mul_a[9]  = s1_py_reg; mul_b[9]  = s1_sy_reg;
        mul_a[10] = s1_py_reg; mul_b[10] = s1_sx_reg;
        mul_a[11] = s1_px_reg; mul_b[11] = s1_sy_reg;
        mul_a[12] = s1_se_reg; mul_b[12] = s1_dz_reg;
        mul_a[13] = s1_sz_reg; mul_b[13] = s1_dt_reg;
        mul_a[14] = s1_se_reg; mul_b[14] = s1_dt_reg;
        mul_a[15] = s1_sz_reg; mul_b[15] = s1_dz_reg;
        mul_a[16] = s1_dx_reg; mul_b[16] = s1_sx_reg;
        mul_a[17] = s1_dy_reg; mul_b[17] = s1_sy_reg;
        mul_a[18] = s1_dy_reg; mul_b[18] = s1_sx_reg;
        mul_a[19] = s1_dx_reg; mul_b[19] = s1_sy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 20; j++)
            begin
                s2_p_reg[j] <= mul_a[j] * mul_b[j];
            end
        end
    end

    // square roots of Pt2, Mt2, M2; entry stage also forms the numerators
    logic [SQIN_BITS-1:0] sa_v_reg  [ROOT_BITS+1][3];
    logic [SQIN_BITS-1:0] sa_v_next [ROOT_BITS+1][3];
    logic [ROOT_BITS-1:0] sa_r_reg  [ROOT_BITS+1][3];
    logic [ROOT_BITS-1:0] sa_r_next [ROOT_BITS+1][3];
    logic [CA_BITS-1:0]   sa_s_reg  [ROOT_BITS+1][3];
    logic [CA_BITS-1:0]   sa_s_next [ROOT_BITS+1][3];
    prk_side_a_t          sa_side_reg  [ROOT_BITS+1];
    prk_side_a_t          sa_side_next [ROOT_BITS+1];

    always_comb
    begin
        logic signed [SQIN_BITS-1:0] pt2;
        logic signed [SQIN_BITS-1:0] mt2;
        logic signed [SQIN_BITS-1:0] m2;
        logic [CA_BITS-1:0]          cand;
        pt2 = SQIN_BITS'(s2_p_reg[0]) + SQIN_BITS'(s2_p_reg[1]);
        mt2 = SQIN_BITS'(s2_p_reg[2]) - SQIN_BITS'(s2_p_reg[3]);
        m2  = mt2 - pt2;
        sa_side_next[0].invalid = (pt2 == '0) || m2[SQIN_BITS-1] || (m2 == '0);
        for (int j = 0; j < 8; j++)
        begin
            if (j == 2 || j == 6)
            begin
                sa_side_next[0].num[j] = NUM_BITS'(s2_p_reg[4+2*j])
                                       + NUM_BITS'(s2_p_reg[5+2*j]);
            end
            else
            begin
                sa_side_next[0].num[j] = NUM_BITS'(s2_p_reg[4+2*j])
                                       - NUM_BITS'(s2_p_reg[5+2*j]);
            end
        end
        sa_v_next[0][0] = pt2;
        sa_v_next[0][1] = mt2;
        sa_v_next[0][2] = m2;
        for (int l = 0; l < 3; l++)
        begin
            sa_r_next[0][l] = '0;
            sa_s_next[0][l] = '0;
        end
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            sa_side_next[k+1] = sa_side_reg[k];
            for (int l = 0; l < 3; l++)
            begin
                cand = sa_s_reg[k][l] + (CA_BITS'(sa_r_reg[k][l]) << (ROOT_BITS - k))
                     + (CA_BITS'(1) << (2 * (ROOT_BITS - 1 - k)));
                sa_v_next[k+1][l] = sa_v_reg[k][l];
                if (cand <= CA_BITS'(sa_v_reg[k][l]))
                begin
                    sa_r_next[k+1][l] = sa_r_reg[k][l] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - k));
                    sa_s_next[k+1][l] = cand;
                end
                else
                begin
                    sa_r_next[k+1][l] = sa_r_reg[k][l];
                    sa_s_next[k+1][l] = sa_s_reg[k][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= ROOT_BITS; k++)
            begin
                sa_v_reg[k]    <= sa_v_next[k];
                sa_r_reg[k]    <= sa_r_next[k];
                sa_s_reg[k]    <= sa_s_next[k];
                sa_side_reg[k] <= sa_side_next[k];
            end
        end
    end

    // first divider bank: kl, e1l, kol, kside, rl, dtl, rol, rside
    logic [NUM_BITS-1:0]  d1_rem_reg  [WORD_BITS+1][8];
    logic [NUM_BITS-1:0]  d1_rem_next [WORD_BITS+1][8];
    logic [WORD_BITS-1:0] d1_q_reg    [WORD_BITS+1][8];
    logic [WORD_BITS-1:0] d1_q_next   [WORD_BITS+1][8];
    logic                 d1_neg_reg  [WORD_BITS+1][8];
    logic                 d1_neg_next [WORD_BITS+1][8];
    logic                 d1_sat_reg  [WORD_BITS+1][8];
    logic                 d1_sat_next [WORD_BITS+1][8];
    prk_side_d_t          d1_side_reg  [WORD_BITS+1];
    prk_side_d_t          d1_side_next [WORD_BITS+1];

    always_comb
    begin
        logic signed [NUM_BITS-1:0] n;
        logic [NUM_BITS-1:0]        mag;
        logic [NUM_BITS-1:0]        sh;
        logic [ROOT_BITS-1:0]       dvs;
        d1_side_next[0].pt      = sa_r_reg[ROOT_BITS][0];
        d1_side_next[0].mt      = sa_r_reg[ROOT_BITS][1];
        d1_side_next[0].m       = sa_r_reg[ROOT_BITS][2];
        d1_side_next[0].invalid = sa_side_reg[ROOT_BITS].invalid;
        for (int j = 0; j < 8; j++)
        begin
            n   = $signed(sa_side_reg[ROOT_BITS].num[j]);
            mag = n[NUM_BITS-1] ? NUM_BITS'(-n) : NUM_BITS'(n);
            dvs = USE_MT[j] ? sa_r_reg[ROOT_BITS][1] : sa_r_reg[ROOT_BITS][0];
            d1_neg_next[0][j] = n[NUM_BITS-1];
            d1_rem_next[0][j] = mag;
            d1_sat_next[0][j] = mag >= (NUM_BITS'(dvs) << WORD_BITS);
            d1_q_next[0][j]   = '0;
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            d1_side_next[k+1] = d1_side_reg[k];
            for (int j = 0; j < 8; j++)
            begin
                dvs = USE_MT[j] ? d1_side_reg[k].mt : d1_side_reg[k].pt;
                sh  = NUM_BITS'(dvs) << (WORD_BITS - 1 - k);
                d1_neg_next[k+1][j] = d1_neg_reg[k][j];
                d1_sat_next[k+1][j] = d1_sat_reg[k][j];
                if (d1_rem_reg[k][j] >= sh)
                begin
                    d1_rem_next[k+1][j] = d1_rem_reg[k][j] - sh;
                    d1_q_next[k+1][j]   = d1_q_reg[k][j]
                                        | (WORD_BITS'(1) << (WORD_BITS - 1 - k));
                end
                else
                begin
                    d1_rem_next[k+1][j] = d1_rem_reg[k][j];
                    d1_q_next[k+1][j]   = d1_q_reg[k][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= WORD_BITS; k++)
            begin
                d1_rem_reg[k]  <= d1_rem_next[k];
                d1_q_reg[k]    <= d1_q_next[k];
                d1_neg_reg[k]  <= d1_neg_next[k];
                d1_sat_reg[k]  <= d1_sat_next[k];
                d1_side_reg[k] <= d1_side_next[k];
            end
        end
    end

    // saturate, cross products, difference
    logic signed [WORD_BITS-1:0] q1_reg [8];
    prk_side_d_t                 q1_side_reg;
    logic signed [ROOT_BITS:0]   mt_s, pt_s;
    logic signed [NUM_BITS-2:0]  mu_reg [4];
    prk_side_b_t                 mu_side_reg;
    logic signed [NUM_BITS-1:0]  n2_reg [2];
    prk_side_b_t                 n2_side_reg;

    assign mt_s = $signed({1'b0, q1_side_reg.mt});
    assign pt_s = $signed({1'b0, q1_side_reg.pt});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 8; j++)
            begin
                q1_reg[j] <= quot_fix(d1_neg_reg[WORD_BITS][j], d1_sat_reg[WORD_BITS][j],
                                      d1_q_reg[WORD_BITS][j]);
            end
            q1_side_reg <= d1_side_reg[WORD_BITS];

            mu_reg[0] <= mt_s * q1_reg[2];
            mu_reg[1] <= pt_s * q1_reg[1];
            mu_reg[2] <= mt_s * q1_reg[6];
            mu_reg[3] <= pt_s * q1_reg[5];
            mu_side_reg.m       <= q1_side_reg.m;
            mu_side_reg.kside   <= q1_reg[3];
            mu_side_reg.klong   <= q1_reg[0];
            mu_side_reg.rside   <= q1_reg[7];
            mu_side_reg.rlong   <= q1_reg[4];
            mu_side_reg.invalid <= q1_side_reg.invalid;

            n2_reg[0]   <= NUM_BITS'(mu_reg[0]) - NUM_BITS'(mu_reg[1]);
            n2_reg[1]   <= NUM_BITS'(mu_reg[2]) - NUM_BITS'(mu_reg[3]);
            n2_side_reg <= mu_side_reg;
        end
    end

    // second divider bank: k_out, r_out by M
    logic [NUM_BITS-1:0]  d2_rem_reg  [WORD_BITS+1][2];
    logic [NUM_BITS-1:0]  d2_rem_next [WORD_BITS+1][2];
    logic [WORD_BITS-1:0] d2_q_reg    [WORD_BITS+1][2];
    logic [WORD_BITS-1:0] d2_q_next   [WORD_BITS+1][2];
    logic                 d2_neg_reg  [WORD_BITS+1][2];
    logic                 d2_neg_next [WORD_BITS+1][2];
    logic                 d2_sat_reg  [WORD_BITS+1][2];
    logic                 d2_sat_next [WORD_BITS+1][2];
    prk_side_b_t          d2_side_reg  [WORD_BITS+1];
    prk_side_b_t          d2_side_next [WORD_BITS+1];

    always_comb
    begin
        logic [NUM_BITS-1:0] mag;
        logic [NUM_BITS-1:0] sh;
        d2_side_next[0] = n2_side_reg;
        for (int j = 0; j < 2; j++)
        begin
            mag = n2_reg[j][NUM_BITS-1] ? NUM_BITS'(-n2_reg[j]) : NUM_BITS'(n2_reg[j]);
            d2_neg_next[0][j] = n2_reg[j][NUM_BITS-1];
            d2_rem_next[0][j] = mag;
            d2_sat_next[0][j] = mag >= (NUM_BITS'(n2_side_reg.m) << WORD_BITS);
            d2_q_next[0][j]   = '0;
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            d2_side_next[k+1] = d2_side_reg[k];
            sh = NUM_BITS'(d2_side_reg[k].m) << (WORD_BITS - 1 - k);
            for (int j = 0; j < 2; j++)
            begin
                d2_neg_next[k+1][j] = d2_neg_reg[k][j];
                d2_sat_next[k+1][j] = d2_sat_reg[k][j];
                if (d2_rem_reg[k][j] >= sh)
                begin
                    d2_rem_next[k+1][j] = d2_rem_reg[k][j] - sh;
                    d2_q_next[k+1][j]   = d2_q_reg[k][j]
                                        | (WORD_BITS'(1) << (WORD_BITS - 1 - k));
                end
                else
                begin
                    d2_rem_next[k+1][j] = d2_rem_reg[k][j];
                    d2_q_next[k+1][j]   = d2_q_reg[k][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= WORD_BITS; k++)
            begin
                d2_rem_reg[k]  <= d2_rem_next[k];
                d2_q_reg[k]    <= d2_q_next[k];
                d2_neg_reg[k]  <= d2_neg_next[k];
                d2_sat_reg[k]  <= d2_sat_next[k];
                d2_side_reg[k] <= d2_side_next[k];
            end
        end
    end

    // saturate, squares
    logic signed [WORD_BITS-1:0] q2_reg [2];
    prk_side_b_t                 q2_side_reg;
    logic [MAG_BITS-1:0]         sq_reg [6];
    prk_side_c_t                 sq_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                q2_reg[j] <= quot_fix(d2_neg_reg[WORD_BITS][j], d2_sat_reg[WORD_BITS][j],
                                      d2_q_reg[WORD_BITS][j]);
            end
            q2_side_reg <= d2_side_reg[WORD_BITS];

            sq_reg[0] <= q2_reg[0] * q2_reg[0];
            sq_reg[1] <= $signed(q2_side_reg.kside) * $signed(q2_side_reg.kside);
            sq_reg[2] <= $signed(q2_side_reg.klong) * $signed(q2_side_reg.klong);
            sq_reg[3] <= q2_reg[1] * q2_reg[1];
            sq_reg[4] <= $signed(q2_side_reg.rside) * $signed(q2_side_reg.rside);
            sq_reg[5] <= $signed(q2_side_reg.rlong) * $signed(q2_side_reg.rlong);
            sq_side_reg.kout    <= q2_reg[0];
            sq_side_reg.kside   <= q2_side_reg.kside;
            sq_side_reg.klong   <= q2_side_reg.klong;
            sq_side_reg.rout    <= q2_reg[1];
            sq_side_reg.rside   <= q2_side_reg.rside;
            sq_side_reg.rlong   <= q2_side_reg.rlong;
            sq_side_reg.invalid <= q2_side_reg.invalid;
        end
    end

    // magnitudes: sum of squares then square root
    logic [MAG_BITS-1:0]  sb_v_reg  [WORD_BITS+1][2];
    logic [MAG_BITS-1:0]  sb_v_next [WORD_BITS+1][2];
    logic [WORD_BITS-1:0] sb_r_reg  [WORD_BITS+1][2];
    logic [WORD_BITS-1:0] sb_r_next [WORD_BITS+1][2];
    logic [CB_BITS-1:0]   sb_s_reg  [WORD_BITS+1][2];
    logic [CB_BITS-1:0]   sb_s_next [WORD_BITS+1][2];
    prk_side_c_t          sb_side_reg  [WORD_BITS+1];
    prk_side_c_t          sb_side_next [WORD_BITS+1];

    always_comb
    begin
        logic [CB_BITS-1:0] cand;
        sb_side_next[0] = sq_side_reg;
        sb_v_next[0][0] = sq_reg[0] + sq_reg[1] + sq_reg[2];
        sb_v_next[0][1] = sq_reg[3] + sq_reg[4] + sq_reg[5];
        for (int l = 0; l < 2; l++)
        begin
            sb_r_next[0][l] = '0;
            sb_s_next[0][l] = '0;
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            sb_side_next[k+1] = sb_side_reg[k];
            for (int l = 0; l < 2; l++)
            begin
                cand = sb_s_reg[k][l] + (CB_BITS'(sb_r_reg[k][l]) << (WORD_BITS - k))
                     + (CB_BITS'(1) << (2 * (WORD_BITS - 1 - k)));
                sb_v_next[k+1][l] = sb_v_reg[k][l];
                if (cand <= CB_BITS'(sb_v_reg[k][l]))
                begin
                    sb_r_next[k+1][l] = sb_r_reg[k][l] | (WORD_BITS'(1) << (WORD_BITS - 1 - k));
                    sb_s_next[k+1][l] = cand;
                end
                else
                begin
                    sb_r_next[k+1][l] = sb_r_reg[k][l];
                    sb_s_next[k+1][l] = sb_s_reg[k][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= WORD_BITS; k++)
            begin
                sb_v_reg[k]    <= sb_v_next[k];
                sb_r_reg[k]    <= sb_r_next[k];
                sb_s_reg[k]    <= sb_s_next[k];
                sb_side_reg[k] <= sb_side_next[k];
            end
        end
    end

    // output register
    prk_kin_t             kin_reg;
    prk_kin_t             kin_next;
    logic [WORD_BITS-1:0] ks_mag;
    logic [WORD_BITS-1:0] rs_mag;

    always_comb
    begin
        prk_side_c_t sd;
        sd     = sb_side_reg[WORD_BITS];
        ks_mag = sb_r_reg[WORD_BITS][0][WORD_BITS-1] ? LIM_POS : sb_r_reg[WORD_BITS][0];
        rs_mag = sb_r_reg[WORD_BITS][1][WORD_BITS-1] ? LIM_POS : sb_r_reg[WORD_BITS][1];
        if (sd.invalid)
        begin
            kin_next         = '0;
            kin_next.invalid = 1'b1;
        end
        else
        begin
            kin_next.k_out   = sd.kout;
            kin_next.k_side  = sd.kside;
            kin_next.k_long  = sd.klong;
            kin_next.k_star  = sd.kout[WORD_BITS-1] ? -ks_mag : ks_mag;
            kin_next.r_out   = sd.rout;
            kin_next.r_side  = sd.rside;
            kin_next.r_long  = sd.rlong;
            kin_next.r_star  = rs_mag[WORD_BITS-2:0];
            kin_next.invalid = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kin_reg <= kin_next;
        end
    end

    assign kin = kin_reg;

`include "assert_macros.svh"

    `PRK_ASSERT_NEXT(a_stall_freezes_pipe, pair_stall, $stable(vld_reg))
    `PRK_ASSERT(a_invalid_zeroes, kin_valid && kin.invalid, kin.k_out == '0 && kin.k_star == '0 && kin.r_star == '0)
    `PRK_ASSERT(a_kstar_sign, kin_valid, kin.k_star[WORD_BITS-1] == kin.k_out[WORD_BITS-1])

endmodule

`default_nettype wire
